// File: rtl/mctt_pkg.sv
`default_nettype none

package mctt_pkg;

  // Sequencer timing.
  localparam int unsigned HISTORY_DEPTH       = 24;
  localparam int unsigned TICKS_PER_BEAT      = 48;
  localparam int unsigned TICKS_PER_SIXTEENTH = 12;
  localparam int unsigned MIDI_PPQ            = 24;
  localparam int unsigned CLOCK_TICKS         = TICKS_PER_BEAT / MIDI_PPQ;

  localparam int unsigned HIST_IDX_W = $clog2(HISTORY_DEPTH);
  localparam int unsigned HIST_CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned HIST_SUM_W = 16 + HIST_CNT_W;
  localparam int unsigned TPM_W      = 25;
  localparam int unsigned DIV_W      = 32;

  // Dividend constants.
  localparam logic [DIV_W-1:0] MS_MILLI_MINUTE = 32'd60000000;
  localparam logic [DIV_W-1:0] MILLI_NUM_K     = 32'(60000000 * CLOCK_TICKS);
  localparam logic [DIV_W-1:0] TENTH_NUM_K     = 32'(600000 * CLOCK_TICKS);

  // Reset state that follows from a tempo of 120 bpm.
  localparam logic [18:0]      TEMPO_RESET      = 19'd120000;
  localparam logic [TPM_W-1:0] TPM_RESET        = 25'(120000 * TICKS_PER_BEAT);
  localparam logic [15:0]      PERIOD_RESET     = 16'(60000000 / (120000 * TICKS_PER_BEAT));
  localparam logic [31:0]      REMAINDER_RESET  = 32'(60000000 % (120000 * TICKS_PER_BEAT));

  // Request kinds.
  typedef enum logic [2:0] {
    REQ_MS_TICK  = 3'd0,
    REQ_CLOCK    = 3'd1,
    REQ_START    = 3'd2,
    REQ_CONTINUE = 3'd3,
    REQ_STOP     = 3'd4
  } req_t;

  // Configuration register indexes.
  localparam logic CFG_INTERNAL_SYNC = 1'b0;
  localparam logic CFG_TEMPO         = 1'b1;

  // Divider result bundle.
  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
    logic [DIV_W-1:0] remainder;
  } div_resp_t;

  // Tick phase divided by three, for phases of one sixteenth.
  function automatic logic [1:0] phase_div3(input logic [3:0] p);
    logic [1:0] r;
    case (p)
      4'd0, 4'd1, 4'd2:  r = 2'd0;
      4'd3, 4'd4, 4'd5:  r = 2'd1;
      4'd6, 4'd7, 4'd8:  r = 2'd2;
      4'd9, 4'd10, 4'd11: r = 2'd3;
      default:           r = 2'd0;
    endcase
    return r;
  endfunction

  // True when the tick phase is a multiple of three.
  function automatic logic phase_mod3_zero(input logic [3:0] p);
    logic r;
    case (p)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 1'b1;
      default:                              r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mctt_div.sv
`default_nettype none

module mctt_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [mctt_pkg::DIV_W-1:0] dividend,
  input  wire logic [mctt_pkg::DIV_W-1:0] divisor,
  output mctt_pkg::div_resp_t             resp
);

  localparam int unsigned CNT_W = $clog2(mctt_pkg::DIV_W + 1);

  logic                       busy;
  logic [CNT_W-1:0]           count;
  logic [mctt_pkg::DIV_W:0]   rem;
  logic [mctt_pkg::DIV_W-1:0] quo;
  logic [mctt_pkg::DIV_W-1:0] dvs;
  logic [mctt_pkg::DIV_W:0]   shifted;
  logic [mctt_pkg::DIV_W:0]   trial;

  // One restoring step a cycle.
  assign shifted = {rem[mctt_pkg::DIV_W-1:0], quo[mctt_pkg::DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      count     <= '0;
      resp.done <= 1'b0;
    end else begin
      resp.done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(mctt_pkg::DIV_W);
        rem   <= '0;
        quo   <= dividend;
        dvs   <= divisor;
      end else if (busy) begin
        rem   <= trial[mctt_pkg::DIV_W] ? shifted : trial;
        quo   <= {quo[mctt_pkg::DIV_W-2:0], ~trial[mctt_pkg::DIV_W]};
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          busy      <= 1'b0;
          resp.done <= 1'b1;
        end
      end
    end
  end

  assign resp.quotient  = quo;
  assign resp.remainder = rem[mctt_pkg::DIV_W-1:0];

endmodule

`default_nettype wire

// File: rtl/midi_clock_tempo_tracker.sv
`default_nettype none

// Channel   Dir  Handshake                     Contents
// s_axis    in   s_axis_tvalid/s_axis_tready   request kind and sequencer state
// m_axis    out  m_axis_tvalid/m_axis_tready   step pulse, sub-steps, tempo estimates
// cfg       in   cfg_valid/cfg_ready           register index and write data
//
// A millisecond tick, start, continue or stop goes through ST_EMIT to its result.
// A MIDI clock in external sync passes the history read-modify-write and, unless
// no nonzero interval is left, three divisions on the one serial divider.
// A tempo or sync write that starts the period division holds the block until it is done.
// Reset is synchronous; the 24 history entries read as zero until written.
// Input is taken only when idle; a finished word waits in the output register.

module midi_clock_tempo_tracker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [0] sequencer_running
  input  wire logic [2:0]  s_axis_tuser,  // [2:0] req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // [0] step_pulse, [2:1] step_index,
                                          // [4:3] nearest_step, [5] restart_steps,
                                          // [25:6] tempo_milli_bpm_est,
                                          // [37:26] tempo_tenth_bpm_est
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [18:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DERIVE,
    ST_HIST,
    ST_DIV_P,
    ST_DIV_M,
    ST_DIV_T,
    ST_EMIT
  } state_t;

  state_t state;

  // Configuration and timing state.
  logic                           internal_sync;
  logic [18:0]                    tempo_milli_bpm;
  logic [31:0]                    phase_accum;
  logic [15:0]                    period_ms;
  logic [31:0]                    period_remainder;
  logic [mctt_pkg::TPM_W-1:0]     ticks_per_minute_milli;
  logic [31:0]                    fraction_accum;
  logic [3:0]                     tick_phase;
  logic [15:0]                    midi_interval;
  logic                           clock_running;
  logic [19:0]                    tempo_milli_reg;
  logic [11:0]                    tempo_tenth_reg;

  // History memory, its valid bits and the running totals.
  logic [15:0]                      hist_mem [mctt_pkg::HISTORY_DEPTH];
  logic [mctt_pkg::HISTORY_DEPTH-1:0] hist_valid;
  logic [15:0]                      hist_rd_data;
  logic                             hist_rd_valid;
  logic                             hist_we;
  logic [mctt_pkg::HIST_IDX_W-1:0]  history_index;
  logic [15:0]                      hist_new;
  logic [mctt_pkg::HIST_SUM_W-1:0]  hist_sum;
  logic [mctt_pkg::HIST_CNT_W-1:0]  hist_count;

  // Result fields being built.
  logic step_pulse;
  logic [1:0] step_index;
  logic restart_steps;

  // Divider interface.
  logic                       div_start;
  logic [mctt_pkg::DIV_W-1:0] div_dividend;
  logic [mctt_pkg::DIV_W-1:0] div_divisor;
  mctt_pkg::div_resp_t        div_resp;

  mctt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .resp     (div_resp)
  );

  // A pending register write has priority, so input waits while one is offered.
  assign s_axis_tready = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ready     = (state == ST_IDLE);

  logic                 in_acc;
  logic                 cfg_acc;
  mctt_pkg::req_t       req;
  logic                 seq_run;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign cfg_acc = cfg_valid && cfg_ready;
  assign req     = mctt_pkg::req_t'(s_axis_tuser);
  assign seq_run = s_axis_tdata[0];

  // Ms tick arithmetic.
  logic [31:0] frac_sum;
  logic        frac_wrap;
  logic [31:0] frac_next;
  logic [31:0] phase_step;
  logic [31:0] phase_tick;
  assign frac_sum   = fraction_accum + period_remainder;
  assign frac_wrap  = (frac_sum >= 32'(ticks_per_minute_milli));
  assign frac_next  = frac_wrap ? frac_sum - 32'(ticks_per_minute_milli) : frac_sum;
  assign phase_step = phase_accum - 32'(period_ms) - 32'(frac_wrap && internal_sync);
  assign phase_tick = (phase_accum[31] ? phase_accum : phase_step) + 32'd1;

  // Derived tempo product for a configuration write.
  logic [18:0]                tempo_new;
  logic [mctt_pkg::TPM_W-1:0] tpm_new;
  assign tempo_new = (cfg_index == mctt_pkg::CFG_TEMPO) ? cfg_data : tempo_milli_bpm;
  assign tpm_new   = mctt_pkg::TPM_W'(tempo_new) * mctt_pkg::TPM_W'(mctt_pkg::TICKS_PER_BEAT);

  // History update from the read of the old entry.
  logic [15:0]                     hist_old;
  logic [mctt_pkg::HIST_SUM_W-1:0] sum_next;
  logic [mctt_pkg::HIST_CNT_W-1:0] count_next;
  assign hist_old   = hist_rd_valid ? hist_rd_data : 16'd0;
  assign sum_next   = hist_sum - mctt_pkg::HIST_SUM_W'(hist_old)
                      + mctt_pkg::HIST_SUM_W'(hist_new);
  assign count_next = hist_count - mctt_pkg::HIST_CNT_W'(hist_old != 16'd0)
                      + mctt_pkg::HIST_CNT_W'(hist_new != 16'd0);

  // Nearest sub-step from the updated phase.
  logic signed [32:0] half_neg;
  logic               near_round;
  logic [3:0]         near_phase;
  assign half_neg   = -$signed({18'd0, period_ms[15:1]});
  assign near_round = $signed({phase_accum[31], phase_accum}) > half_neg;
  assign near_phase = (tick_phase + 4'(near_round) >= 4'(mctt_pkg::TICKS_PER_SIXTEENTH))
                      ? 4'd0 : tick_phase + 4'(near_round);

  // History memory: one write and one registered read.
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[history_index] <= hist_new;
    end
    hist_rd_data <= hist_mem[history_index];
  end

  // Control, state update and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state                  <= ST_IDLE;
      internal_sync          <= 1'b1;
      tempo_milli_bpm        <= mctt_pkg::TEMPO_RESET;
      phase_accum            <= '0;
      period_ms              <= mctt_pkg::PERIOD_RESET;
      period_remainder       <= mctt_pkg::REMAINDER_RESET;
      ticks_per_minute_milli <= mctt_pkg::TPM_RESET;
      fraction_accum         <= '0;
      tick_phase             <= '0;
      midi_interval          <= '0;
      clock_running          <= 1'b0;
      tempo_milli_reg        <= '0;
      tempo_tenth_reg        <= '0;
      hist_valid             <= '0;
      hist_rd_valid          <= 1'b0;
      hist_we                <= 1'b0;
      history_index          <= '0;
      hist_sum               <= '0;
      hist_count             <= '0;
      div_start              <= 1'b0;
      m_axis_tvalid          <= 1'b0;
    end else begin
      div_start <= 1'b0;
      hist_we   <= 1'b0;
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cfg_acc) begin
            if (cfg_index == mctt_pkg::CFG_INTERNAL_SYNC) begin
              if (cfg_data[0] != internal_sync) begin
                internal_sync  <= cfg_data[0];
                phase_accum    <= '0;
                fraction_accum <= '0;
              end
            end else begin
              tempo_milli_bpm <= cfg_data;
            end
            // Derive the period when the block runs (or now runs) on its own tempo.
            if ((cfg_index == mctt_pkg::CFG_TEMPO && internal_sync) ||
                (cfg_index == mctt_pkg::CFG_INTERNAL_SYNC && cfg_data[0] && !internal_sync)) begin
              ticks_per_minute_milli <= tpm_new;
              fraction_accum         <= '0;
              if (tpm_new != '0) begin
                div_start    <= 1'b1;
                div_dividend <= mctt_pkg::MS_MILLI_MINUTE;
                div_divisor  <= 32'(tpm_new);
                state        <= ST_DERIVE;
              end
            end
          end else if (in_acc) begin
            step_pulse    <= 1'b0;
            step_index    <= 2'd0;
            restart_steps <= 1'b0;
            state         <= ST_EMIT;
            case (req)
              mctt_pkg::REQ_MS_TICK: begin
                if (seq_run && (internal_sync || clock_running)) begin
                  phase_accum <= phase_tick;
                  if (!phase_accum[31]) begin
                    fraction_accum <= frac_next;
                    if (mctt_pkg::phase_mod3_zero(tick_phase)) begin
                      step_pulse <= 1'b1;
                      step_index <= mctt_pkg::phase_div3(tick_phase);
                    end
                    tick_phase <= (tick_phase == 4'(mctt_pkg::TICKS_PER_SIXTEENTH - 1))
                                  ? 4'd0 : tick_phase + 4'd1;
                  end
                  if (clock_running && midi_interval != 16'hFFFF) begin
                    midi_interval <= midi_interval + 16'd1;
                  end
                end
              end
              mctt_pkg::REQ_CLOCK: begin
                if (!internal_sync) begin
                  phase_accum   <= phase_accum
                                   + 32'(17'(mctt_pkg::CLOCK_TICKS) * 17'(period_ms))
                                   - 32'(midi_interval);
                  hist_new      <= midi_interval;
                  midi_interval <= '0;
                  hist_rd_valid <= hist_valid[history_index];
                  state         <= ST_HIST;
                end
              end
              mctt_pkg::REQ_START: begin
                if (!internal_sync) begin
                  restart_steps <= 1'b1;
                  midi_interval <= '0;
                  phase_accum   <= '0;
                  tick_phase    <= '0;
                end
                clock_running <= 1'b1;
              end
              mctt_pkg::REQ_CONTINUE: begin
                clock_running <= 1'b1;
              end
              mctt_pkg::REQ_STOP: begin
                clock_running <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_DERIVE: begin
          if (div_resp.done) begin
            period_ms        <= (div_resp.quotient > 32'd65535)
                                ? 16'hFFFF : div_resp.quotient[15:0];
            period_remainder <= div_resp.remainder;
            state            <= ST_IDLE;
          end
        end
        ST_HIST: begin
          // Write back the new interval and update the running totals.
          hist_we                   <= 1'b1;
          hist_valid[history_index] <= 1'b1;
          hist_sum                  <= sum_next;
          hist_count                <= count_next;
          if (count_next == '0) begin
            state <= ST_EMIT;
          end else begin
            div_start    <= 1'b1;
            div_dividend <= 32'(sum_next);
            div_divisor  <= 32'(count_next) * 32'(mctt_pkg::CLOCK_TICKS);
            state        <= ST_DIV_P;
          end
        end
        ST_DIV_P: begin
          if (div_resp.done) begin
            period_ms    <= (div_resp.quotient > 32'd65535)
                            ? 16'hFFFF : div_resp.quotient[15:0];
            div_start    <= 1'b1;
            div_dividend <= mctt_pkg::MILLI_NUM_K * 32'(hist_count);
            div_divisor  <= 32'(hist_sum) * 32'(mctt_pkg::TICKS_PER_BEAT);
            state        <= ST_DIV_M;
          end
        end
        ST_DIV_M: begin
          if (div_resp.done) begin
            tempo_milli_reg <= (div_resp.quotient > 32'd1048575)
                               ? 20'hFFFFF : div_resp.quotient[19:0];
            div_start       <= 1'b1;
            div_dividend    <= mctt_pkg::TENTH_NUM_K * 32'(hist_count);
            state           <= ST_DIV_T;
          end
        end
        ST_DIV_T: begin
          if (div_resp.done) begin
            tempo_tenth_reg <= (div_resp.quotient > 32'd4095)
                               ? 12'hFFF : div_resp.quotient[11:0];
            state           <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {2'b00, tempo_tenth_reg, tempo_milli_reg, restart_steps,
                              mctt_pkg::phase_div3(near_phase), step_index, step_pulse};
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      // Advance the history index after the write-back cycle.
      if (hist_we) begin
        history_index <= (history_index == mctt_pkg::HIST_IDX_W'(mctt_pkg::HISTORY_DEPTH - 1))
                         ? '0 : history_index + 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    hist_count <= mctt_pkg::HIST_CNT_W'(mctt_pkg::HISTORY_DEPTH))
    else $error("history count beyond depth");
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    history_index < mctt_pkg::HIST_IDX_W'(mctt_pkg::HISTORY_DEPTH))
    else $error("history index beyond depth");
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    tick_phase < 4'(mctt_pkg::TICKS_PER_SIXTEENTH))
    else $error("tick phase beyond sixteenth");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second word taken while one is in work");
`endif

endmodule

`default_nettype wire

// File: sim/tb_midi_clock_tempo_tracker.sv
`default_nettype none

module tb_midi_clock_tempo_tracker;

  timeunit 1ns;
  timeprecision 1ps;

  // Request kinds outside the defined set.
  localparam logic [2:0] REQ_RESERVED_5 = 3'd5;
  localparam logic [2:0] REQ_RESERVED_6 = 3'd6;
  localparam logic [2:0] REQ_RESERVED_7 = 3'd7;

  typedef struct packed {
    logic        pulse;
    logic [1:0]  index;
    logic [1:0]  nearest;
    logic        restart;
    logic [19:0] milli;
    logic [11:0] tenth;
  } step_word_t;

  typedef struct packed {
    logic       go_external;  // write internal_sync = 0 before this row
    logic [2:0] req;
    logic       running;
    logic       typed;
    step_word_t typed_word;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [18:0] cfg_data = '0;

  midi_clock_tempo_tracker u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Tracker state mirrored by the predictor.
  logic        sync_internal;
  logic [18:0] tempo_cfg;
  logic [31:0] phase_acc;
  logic [31:0] tick_period;
  logic [31:0] period_rem;
  logic [31:0] ticks_per_min;
  logic [31:0] frac_acc;
  logic [3:0]  tick_ph;
  logic [31:0] clock_gap;
  logic [15:0] gap_history [mctt_pkg::HISTORY_DEPTH];
  int unsigned gap_slot;
  logic        ext_clock_on;
  logic [19:0] est_milli;
  logic [11:0] est_tenth;

  step_word_t pending_steps [$];
  int         mismatches = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  function automatic void derive_tick_period();
    longint unsigned tpm;
    longint unsigned p;
    tpm = longint'(tempo_cfg) * mctt_pkg::TICKS_PER_BEAT;
    ticks_per_min = tpm[31:0];
    if (tpm != 0) begin
      p = 64'd60000000 / tpm;
      tick_period = (p > 65535) ? 32'd65535 : p[31:0];
      period_rem = 32'(64'd60000000 % tpm);
    end
    frac_acc = '0;
  endfunction

  function automatic void reset_tracker();
    sync_internal = 1'b1;
    tempo_cfg = mctt_pkg::TEMPO_RESET;
    phase_acc = '0;
    derive_tick_period();
    tick_ph = '0;
    clock_gap = '0;
    foreach (gap_history[i]) gap_history[i] = '0;
    gap_slot = 0;
    ext_clock_on = 1'b0;
    est_milli = '0;
    est_tenth = '0;
  endfunction

  function automatic void apply_register(logic idx, logic [18:0] val);
    if (idx == mctt_pkg::CFG_INTERNAL_SYNC) begin
      if (val[0] != sync_internal) begin
        sync_internal = val[0];
        phase_acc = '0;
        frac_acc = '0;
        if (sync_internal) derive_tick_period();
      end
    end else begin
      tempo_cfg = val;
      if (sync_internal) derive_tick_period();
    end
  endfunction

  // A MIDI clock in external sync: phase correction and tempo averaging.
  function automatic void take_midi_clock();
    longint unsigned sum;
    longint unsigned cnt;
    longint unsigned p, m, t;
    sum = 0;
    cnt = 0;
    if (sync_internal) return;
    phase_acc = phase_acc + mctt_pkg::CLOCK_TICKS * tick_period - clock_gap;
    if (gap_slot >= mctt_pkg::HISTORY_DEPTH) gap_slot = 0;
    gap_history[gap_slot] = clock_gap[15:0];
    clock_gap = '0;
    gap_slot = (gap_slot + 1) % mctt_pkg::HISTORY_DEPTH;
    foreach (gap_history[i]) begin
      if (gap_history[i] != 0) begin
        sum += gap_history[i];
        cnt++;
      end
    end
    if (cnt == 0) return;
    p = sum / (mctt_pkg::CLOCK_TICKS * cnt);
    m = (64'd60000000 * mctt_pkg::CLOCK_TICKS * cnt) / (mctt_pkg::TICKS_PER_BEAT * sum);
    t = (64'd600000 * mctt_pkg::CLOCK_TICKS * cnt) / (mctt_pkg::TICKS_PER_BEAT * sum);
    tick_period = (p > 65535) ? 32'd65535 : p[31:0];
    est_milli = (m > 1048575) ? 20'hFFFFF : m[19:0];
    est_tenth = (t > 4095) ? 12'hFFF : t[11:0];
  endfunction

  // Advances the tracker by one request and returns the word it produces.
  function automatic step_word_t track_request(logic [2:0] req, logic running);
    step_word_t w;
    longint     pa_s;
    longint     lim;
    logic [3:0] ph;
    w = '0;
    case (req)
      mctt_pkg::REQ_MS_TICK: begin
        if (running && (sync_internal || ext_clock_on)) begin
          if (!phase_acc[31]) begin
            phase_acc = phase_acc - tick_period;
            frac_acc = frac_acc + period_rem;
            if (frac_acc >= ticks_per_min) begin
              frac_acc = frac_acc - ticks_per_min;
              if (sync_internal) phase_acc = phase_acc - 1;
            end
            if (tick_ph % 3 == 0) begin
              w.pulse = 1'b1;
              w.index = 2'(tick_ph / 3);
            end
            tick_ph = (tick_ph + 1 >= mctt_pkg::TICKS_PER_SIXTEENTH) ? 4'd0 : tick_ph + 1;
          end
          phase_acc = phase_acc + 1;
          if (ext_clock_on && clock_gap < 65535) clock_gap = clock_gap + 1;
        end
      end
      mctt_pkg::REQ_CLOCK: take_midi_clock();
      mctt_pkg::REQ_START: begin
        if (!sync_internal) begin
          w.restart = 1'b1;
          clock_gap = '0;
          phase_acc = '0;
          tick_ph = '0;
        end
        ext_clock_on = 1'b1;
      end
      mctt_pkg::REQ_CONTINUE: ext_clock_on = 1'b1;
      mctt_pkg::REQ_STOP: ext_clock_on = 1'b0;
      default: ;
    endcase
    pa_s = longint'($signed(phase_acc));
    lim = -longint'(tick_period / 2);
    ph = tick_ph + ((pa_s > lim) ? 4'd1 : 4'd0);
    w.nearest = 2'((ph % mctt_pkg::TICKS_PER_SIXTEENTH) / 3);
    w.milli = est_milli;
    w.tenth = est_tenth;
    return w;
  endfunction

  // Receiver stalls.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Output checker.
  always @(posedge clk) begin
    step_word_t got;
    step_word_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.pulse = m_axis_tdata[0];
      got.index = m_axis_tdata[2:1];
      got.nearest = m_axis_tdata[4:3];
      got.restart = m_axis_tdata[5];
      got.milli = m_axis_tdata[25:6];
      got.tenth = m_axis_tdata[37:26];
      if (pending_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_axis_tdata);
      end else begin
        want = pending_steps.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"word mismatch: pulse %0d/%0d index %0d/%0d nearest %0d/%0d",
                      " restart %0d/%0d milli %0d/%0d tenth %0d/%0d"},
                     want.pulse, got.pulse, want.index, got.index, want.nearest,
                     got.nearest, want.restart, got.restart, want.milli, got.milli,
                     want.tenth, got.tenth);
        end
      end
    end
  end

  // Sends one request; a typed word replaces the predicted one when given.
  task automatic send_request(logic [2:0] req, logic running, logic typed = 1'b0,
                              step_word_t typed_word = '0);
    int         gap;
    step_word_t w;
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, running};
    s_axis_tuser <= req;
    do @(posedge clk); while (!s_axis_tready);
    w = track_request(req, running);
    pending_steps.push_back(typed ? typed_word : w);
  endtask

  // Lets the block drain, then writes one register.
  task automatic write_register(logic idx, logic [18:0] val);
    s_axis_tvalid <= 1'b0;
    wait (pending_steps.size() == 0);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_register(idx, val);
  endtask

  // One random stretch of requests; in external sync mostly tick runs closed by a clock.
  task automatic random_segment(int count);
    int n;
    int k;
    int pick;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 9);
      if (pick <= 6) begin
        k = $urandom_range(0, 6);
        repeat (k) send_request(mctt_pkg::REQ_MS_TICK, $urandom_range(0, 15) != 0);
        if (sync_internal && pick > 1) k = k;
        else send_request(mctt_pkg::REQ_CLOCK, $urandom_range(0, 1));
        n += k + 1;
      end else if (pick == 7) begin
        send_request(3'($urandom_range(mctt_pkg::REQ_START, mctt_pkg::REQ_STOP)),
                     $urandom_range(0, 1));
        n++;
      end else if (pick == 8) begin
        send_request(3'($urandom_range(0, 7)), $urandom_range(0, 1));
        n++;
      end else begin
        send_request(mctt_pkg::REQ_MS_TICK, 1'b0);
        n++;
      end
    end
  endtask

  directed_row_t directed [25] = '{
    '{1'b0, mctt_pkg::REQ_MS_TICK, 1'b1, 1'b1, '{1'b1, 2'd0, 2'd0, 1'b0, 20'd0, 12'd0}},
    '{1'b0, mctt_pkg::REQ_MS_TICK, 1'b1, 1'b0, '0},
    '{1'b0, mctt_pkg::REQ_MS_TICK, 1'b1, 1'b0, '0},
    '{1'b0, mctt_pkg::REQ_MS_TICK, 1'b1, 1'b0, '0},
    '{1'b0, mctt_pkg::REQ_MS_TICK, 1'b0, 1'b0, '0},
    '{1'b0, REQ_RESERVED_5, 1'b1, 1'b0, '0},
    '{1'b0, REQ_RESERVED_6, 1'b0, 1'b0, '0},
    '{1'b0, REQ_RESERVED_7, 1'b1, 1'b0, '0},
    '{1'b0, mctt_pkg::REQ_CLOCK, 1'b1, 1'b0, '0},
    '{1'b0, mctt_pkg::REQ_START, 1'b1, 1'b0, '0},
    '{1'b0, mctt_pkg::REQ_CONTINUE, 1'b0, 1'b0, '0},
    '{1'b0, mctt_pkg::REQ_STOP, 1'b1, 1'b0, '0},
    '{1'b0, mctt_pkg::REQ_MS_TICK, 1'b1, 1'b0, '0},
    '{1'b1, mctt_pkg::REQ_MS_TICK, 1'b1, 1'b0, '0},
    '{1'b0, mctt_pkg::REQ_CLOCK, 1'b1, 1'b0, '0},
    '{1'b0, mctt_pkg::REQ_START, 1'b1, 1'b0, '0},
    '{1'b0, mctt_pkg::REQ_MS_TICK, 1'b1, 1'b0, '0},
    '{1'b0, mctt_pkg::REQ_CLOCK, 1'b0, 1'b0, '0},
    '{1'b0, mctt_pkg::REQ_MS_TICK, 1'b1, 1'b0, '0},
    '{1'b0, mctt_pkg::REQ_MS_TICK, 1'b1, 1'b0, '0},
    '{1'b0, mctt_pkg::REQ_CLOCK, 1'b1, 1'b0, '0},
    '{1'b0, mctt_pkg::REQ_STOP, 1'b1, 1'b0, '0},
    '{1'b0, mctt_pkg::REQ_MS_TICK, 1'b1, 1'b0, '0},
    '{1'b0, mctt_pkg::REQ_CONTINUE, 1'b1, 1'b0, '0},
    '{1'b0, mctt_pkg::REQ_MS_TICK, 1'b1, 1'b0, '0}
  };

  logic [18:0] tempo_choices [6] = '{19'd20000, 19'd300000, 19'h7FFFF, 19'd0, 19'd1,
                                     19'd120000};

  // Main sequence.
  initial begin
    int waited;
    reset_tracker();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].go_external) write_register(mctt_pkg::CFG_INTERNAL_SYNC, 19'd0);
      send_request(directed[i].req, directed[i].running, directed[i].typed,
                   directed[i].typed_word);
    end

    // Three idle profiles, each with several register settings.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 66 : 0;
      recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 32 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        write_register(mctt_pkg::CFG_TEMPO,
                       (seg == 3) ? 19'($urandom_range(20000, 300000)) :
                       tempo_choices[(phase * 3 + seg) % 6]);
        write_register(mctt_pkg::CFG_INTERNAL_SYNC, 19'($urandom_range(0, 1)));
        random_segment(80);
      end
    end

    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (pending_steps.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_steps.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
